// ===== sv/cggf_pkg.sv =====
// shared types, codes and constant helpers of the coarse grid gravity field
package cggf_pkg;

    localparam int IDX_W = 16;
    localparam int OFS_W = 6;
    localparam int RAD_W = 5;
    localparam int KX_W  = 35;

    localparam logic [1:0] ACT_MOVE   = 2'd0;
    localparam logic [1:0] ACT_RECOMP = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam logic [1:0] CFG_CELL_SPAN = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_RADIUS    = 2'd2;
    localparam logic [1:0] CFG_GAIN      = 2'd3;

    localparam logic signed [47:0] F48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] F48_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [9:0]  prev_x;
        logic [9:0]  prev_y;
        logic        prev_valid;
        logic [15:0] particle_mass;
    } t_in;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
    } t_out;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] new_idx;
        logic             new_ok;
        logic [IDX_W-1:0] old_idx;
        logic             old_ok;
        logic [15:0]      mass;
    } t_cmd;

    // floor(2^30 / d^3) with d^2 = a^2 + b^2, found bit by bit
    function automatic logic [30:0] inv_cube(int a, int b);
        logic [127:0] d6;
        logic [127:0] t;
        logic [30:0]  r;
        int           d2;
        d2 = a * a + b * b;
        d6 = 128'(d2) * 128'(d2) * 128'(d2);
        r  = '0;
        if (d2 != 0) begin
            for (int k = 30; k >= 0; k--) begin
                t = 128'(r | (31'd1 << k));
                if (t * t * d6 <= (128'd1 << 60)) begin
                    r = r | (31'd1 << k);
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/cggf_ram.sv =====
// generic single write port ram with registered read
module cggf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/cggf_fifo.sv =====
// small first-in first-out queue of words
module cggf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!do_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

// ===== sv/cggf_front.sv =====
// front end: takes a word, divides positions by the cell span, builds a command
module cggf_front import cggf_pkg::*; #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_in        i_item,
    input  logic [4:0] i_cell_span,
    input  logic       i_q_full,
    output logic       o_busy,
    output logic       o_push,
    output t_cmd       o_cmd
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0] r_state, n_state;
    t_in        r_item;
    logic [4:0] r_div;
    logic [2:0] r_step, n_step;
    logic [9:0] r_num [4];
    logic [9:0] r_quo [4];
    logic [5:0] r_rem [4];
    logic [9:0] n_num [4];
    logic [9:0] n_quo [4];
    logic [5:0] n_rem [4];
    logic [3:0] ok;
    logic [IDX_W-1:0] idx_n, idx_o;

    // two quotient bits per cycle on each of the four coordinates
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            n_num[l] = r_num[l];
            n_quo[l] = r_quo[l];
            n_rem[l] = r_rem[l];
            for (int s = 0; s < 2; s++) begin
                n_rem[l] = {n_rem[l][4:0], n_num[l][9]};
                n_num[l] = {n_num[l][8:0], 1'b0};
                if (n_rem[l] >= {1'b0, r_div}) begin
                    n_rem[l] = n_rem[l] - {1'b0, r_div};
                    n_quo[l] = {n_quo[l][8:0], 1'b1};
                end else begin
                    n_quo[l] = {n_quo[l][8:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_take) begin
                    n_state = F_DIV;
                    n_step  = '0;
                end
            end
            F_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == 3'd4) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_take) begin
            r_item   <= i_item;
            r_div    <= (i_cell_span == 5'd0) ? 5'd1 : i_cell_span;
            r_num[0] <= i_item.pos_x;
            r_num[1] <= i_item.pos_y;
            r_num[2] <= i_item.prev_x;
            r_num[3] <= i_item.prev_y;
            for (int l = 0; l < 4; l++) begin
                r_quo[l] <= '0;
                r_rem[l] <= '0;
            end
        end else if (r_state == F_DIV) begin
            for (int l = 0; l < 4; l++) begin
                r_num[l] <= n_num[l];
                r_quo[l] <= n_quo[l];
                r_rem[l] <= n_rem[l];
            end
        end
    end

    // grid bounds and flat cell index
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            ok[l] = (l % 2 == 0) ? (11'(r_quo[l]) < 11'(GRID_W)) : (11'(r_quo[l]) < 11'(GRID_H));
        end
        idx_n = IDX_W'(20'(r_quo[0]) + 20'(GRID_W) * 20'(r_quo[1]));
        idx_o = IDX_W'(20'(r_quo[2]) + 20'(GRID_W) * 20'(r_quo[3]));
    end

    assign o_busy        = (r_state != F_IDLE);
    assign o_cmd.action  = r_item.action;
    assign o_cmd.new_idx = idx_n;
    assign o_cmd.new_ok  = ok[0] & ok[1];
    assign o_cmd.old_idx = idx_o;
    assign o_cmd.old_ok  = r_item.prev_valid & ok[2] & ok[3];
    assign o_cmd.mass    = r_item.particle_mass;
endmodule

// ===== sv/cggf_back.sv =====
// back end: mass and field memories, move, recompute and query sequencer
module cggf_back import cggf_pkg::*; #(
    parameter int GRID_W     = 64,
    parameter int GRID_H     = 64,
    parameter int MAX_RADIUS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    output logic        o_q_pop,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_threshold,
    input  logic [3:0]  i_radius,
    input  logic [31:0] i_gain,
    input  logic        i_out_full,
    output logic        o_out_push,
    output t_out        o_result,
    output logic        o_clearing
);
    localparam int NCELLS = GRID_W * GRID_H;
    localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int XW     = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YW     = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int SIDE   = MAX_RADIUS + 1;
    localparam int TN     = SIDE * SIDE;
    localparam int TW     = $clog2(TN);
    localparam logic [CW-1:0]    LAST   = CW'(NCELLS - 1);
    localparam logic [XW-1:0]    X_LAST = XW'(GRID_W - 1);
    localparam logic [RAD_W-1:0] RMAX   = RAD_W'(MAX_RADIUS);

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_MV_NRD  = 5'd2;
    localparam logic [4:0] S_MV_NWR  = 5'd3;
    localparam logic [4:0] S_MV_ORD  = 5'd4;
    localparam logic [4:0] S_MV_OWR  = 5'd5;
    localparam logic [4:0] S_Q_RD    = 5'd6;
    localparam logic [4:0] S_Q_SGN   = 5'd7;
    localparam logic [4:0] S_Q_M1    = 5'd8;
    localparam logic [4:0] S_Q_M2    = 5'd9;
    localparam logic [4:0] S_Q_OUT   = 5'd10;
    localparam logic [4:0] S_RC_CLR  = 5'd11;
    localparam logic [4:0] S_RC_SRD  = 5'd12;
    localparam logic [4:0] S_RC_SCHK = 5'd13;
    localparam logic [4:0] S_RC_OFF  = 5'd14;
    localparam logic [4:0] S_RC_MUL  = 5'd15;
    localparam logic [4:0] S_RC_ADD  = 5'd16;

    // per offset factors |j|*R and |i|*R, built at elaboration
    logic [KX_W-1:0] tab_kx [TN];
    logic [KX_W-1:0] tab_ky [TN];
    for (genvar ga = 0; ga < SIDE; ga++) begin : g_ta
        for (genvar gb = 0; gb < SIDE; gb++) begin : g_tb
            assign tab_kx[ga * SIDE + gb] = KX_W'(gb) * KX_W'(inv_cube(ga, gb));
            assign tab_ky[ga * SIDE + gb] = KX_W'(ga) * KX_W'(inv_cube(ga, gb));
        end
    end

    function automatic logic signed [47:0] sat_add48(logic signed [47:0] a,
                                                     logic signed [48:0] b);
        logic signed [48:0] s;
        s = 49'(a) + b;
        if (s > 49'(F48_MAX)) begin
            return F48_MAX;
        end else if (s < 49'(F48_MIN)) begin
            return F48_MIN;
        end
        return s[47:0];
    endfunction

    logic [4:0]              r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [CW-1:0]           r_addr, n_addr;
    logic [XW-1:0]           r_sx, n_sx;
    logic [YW-1:0]           r_sy, n_sy;
    logic signed [OFS_W-1:0] r_i, n_i, r_j, n_j;
    logic [RAD_W-1:0]        r_r, n_r;
    logic [31:0]             r_m, n_m;
    logic [KX_W-1:0]         r_kx, n_kx, r_ky, n_ky;
    logic                    r_sgnx, n_sgnx, r_sgny, n_sgny;
    logic [CW-1:0]           r_tgt, n_tgt;
    logic [44:0]             r_px, n_px, r_py, n_py;
    logic [95:0]             r_fd, n_fd;
    logic                    r_qzero, n_qzero;
    logic                    r_neg [2];
    logic                    n_neg [2];
    logic [47:0]             r_mag [2];
    logic [47:0]             n_mag [2];
    logic [63:0]             r_p [2];
    logic [63:0]             n_p [2];
    logic [63:0]             r_a [2];
    logic [63:0]             n_a [2];
    logic [31:0]             r_b [2];
    logic [31:0]             n_b [2];

    logic          m_we, m_re, f_we, f_re;
    logic [CW-1:0] m_waddr, m_raddr, f_waddr, f_raddr;
    logic [32:0]   m_wdata, m_rdata;
    logic [95:0]   f_wdata, f_rdata;

    cggf_ram #(.WIDTH(33), .DEPTH(NCELLS)) u_mass_ram (
        .i_clk  (i_clk),
        .i_we   (m_we),
        .i_waddr(m_waddr),
        .i_wdata(m_wdata),
        .i_re   (m_re),
        .i_raddr(m_raddr),
        .o_rdata(m_rdata)
    );

    cggf_ram #(.WIDTH(96), .DEPTH(NCELLS)) u_field_ram (
        .i_clk  (i_clk),
        .i_we   (f_we),
        .i_waddr(f_waddr),
        .i_wdata(f_wdata),
        .i_re   (f_re),
        .i_raddr(f_raddr),
        .o_rdata(f_rdata)
    );

    logic signed [OFS_W-1:0] rs;
    logic [RAD_W-1:0]        ai, aj;
    logic [11:0]             d2;
    logic signed [9:0]       tx, ty;
    logic                    use_off;
    logic [CW-1:0]           tgt;
    logic [TW-1:0]           tix;
    logic [32:0]             msum;
    logic [31:0]             mnew;
    logic signed [47:0]      fx, fy;
    logic [63:0]             q;
    logic [47:0]             qmag [2];
    logic [47:0]             res [2];
    logic                    adv_off, adv_cell;

    // offset geometry for the current source cell and offset
    always_comb begin
        rs  = $signed({1'b0, r_r});
        ai  = r_i[OFS_W-1] ? RAD_W'(-r_i) : RAD_W'(r_i);
        aj  = r_j[OFS_W-1] ? RAD_W'(-r_j) : RAD_W'(r_j);
        d2  = 12'(ai) * 12'(ai) + 12'(aj) * 12'(aj);
        tx  = $signed(10'(r_sx)) + 10'(r_j);
        ty  = $signed(10'(r_sy)) + 10'(r_i);
        use_off = (d2 != 12'd0) && (d2 <= 12'(r_r) * 12'(r_r))
                  && !tx[9] && (tx < $signed(10'(GRID_W)))
                  && !ty[9] && (ty < $signed(10'(GRID_H)));
        tgt = CW'(20'(unsigned'(tx)) + 20'(GRID_W) * 20'(unsigned'(ty)));
        tix = TW'(10'(ai) * 10'(SIDE) + 10'(aj));
    end

    // query result: saturate magnitude, then put the sign back
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            q       = r_a[l] + 64'(r_b[l]);
            qmag[l] = (q > 64'(F48_MAX)) ? 48'(F48_MAX) : q[47:0];
            res[l]  = r_neg[l] ? -qmag[l] : qmag[l];
        end
    end

    assign o_result.force_x = res[0];
    assign o_result.force_y = res[1];
    assign o_clearing       = (r_state == S_CLR);

    always_comb begin
        n_state = r_state;  n_cmd  = r_cmd;   n_addr = r_addr;
        n_sx    = r_sx;     n_sy   = r_sy;    n_i    = r_i;     n_j = r_j;
        n_r     = r_r;      n_m    = r_m;     n_kx   = r_kx;    n_ky = r_ky;
        n_sgnx  = r_sgnx;   n_sgny = r_sgny;  n_tgt  = r_tgt;
        n_px    = r_px;     n_py   = r_py;    n_fd   = r_fd;    n_qzero = r_qzero;
        for (int l = 0; l < 2; l++) begin
            n_neg[l] = r_neg[l];
            n_mag[l] = r_mag[l];
            n_p[l]   = r_p[l];
            n_a[l]   = r_a[l];
            n_b[l]   = r_b[l];
        end
        m_we = 1'b0; m_waddr = r_addr; m_wdata = '0; m_re = 1'b0; m_raddr = r_addr;
        f_we = 1'b0; f_waddr = r_addr; f_wdata = '0; f_re = 1'b0; f_raddr = r_addr;
        o_q_pop    = 1'b0;
        o_out_push = 1'b0;
        adv_off    = 1'b0;
        adv_cell   = 1'b0;
        msum = '0;
        mnew = '0;
        fx   = '0;
        fy   = '0;

        case (r_state)
            S_CLR: begin
                m_we = 1'b1;
                f_we = 1'b1;
                if (r_addr == LAST) begin
                    n_state = S_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_cmd;
                    case (i_cmd.action)
                        ACT_MOVE:   n_state = S_MV_NRD;
                        ACT_RECOMP: begin
                            n_state = S_RC_CLR;
                            n_addr  = '0;
                            n_r     = (RAD_W'(i_radius) > RMAX) ? RMAX : RAD_W'(i_radius);
                        end
                        ACT_QUERY:  n_state = S_Q_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_MV_NRD: begin
                if (r_cmd.new_ok) begin
                    m_re    = 1'b1;
                    m_raddr = r_cmd.new_idx[CW-1:0];
                    n_state = S_MV_NWR;
                end else begin
                    n_state = S_MV_ORD;
                end
            end
            S_MV_NWR: begin
                msum    = 33'(m_rdata[31:0]) + 33'(r_cmd.mass);
                mnew    = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
                m_we    = 1'b1;
                m_waddr = r_cmd.new_idx[CW-1:0];
                m_wdata = {(mnew >= i_threshold), mnew};
                n_state = S_MV_ORD;
            end
            S_MV_ORD: begin
                if (r_cmd.old_ok) begin
                    m_re    = 1'b1;
                    m_raddr = r_cmd.old_idx[CW-1:0];
                    n_state = S_MV_OWR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MV_OWR: begin
                mnew    = (m_rdata[31:0] > 32'(r_cmd.mass))
                          ? m_rdata[31:0] - 32'(r_cmd.mass) : 32'd0;
                m_we    = 1'b1;
                m_waddr = r_cmd.old_idx[CW-1:0];
                m_wdata = {(mnew >= i_threshold), mnew};
                n_state = S_IDLE;
            end
            S_Q_RD: begin
                f_re    = r_cmd.new_ok;
                f_raddr = r_cmd.new_idx[CW-1:0];
                n_qzero = ~r_cmd.new_ok;
                n_state = S_Q_SGN;
            end
            S_Q_SGN: begin
                fx = $signed(f_rdata[95:48]);
                fy = $signed(f_rdata[47:0]);
                // y lane works on the negated field
                n_neg[0] = ~r_qzero & fx[47];
                n_mag[0] = r_qzero ? 48'd0 : (fx[47] ? 48'(-fx) : 48'(fx));
                n_neg[1] = ~r_qzero & ~fy[47] & (fy != 48'sd0);
                n_mag[1] = r_qzero ? 48'd0 : (fy[47] ? 48'(-fy) : 48'(fy));
                n_state  = S_Q_M1;
            end
            S_Q_M1: begin
                for (int l = 0; l < 2; l++) begin
                    n_p[l] = 64'(r_mag[l]) * 64'(r_cmd.mass);
                end
                n_state = S_Q_M2;
            end
            S_Q_M2: begin
                for (int l = 0; l < 2; l++) begin
                    n_a[l] = 64'(r_p[l][63:32]) * 64'(i_gain);
                    n_b[l] = 32'((64'(r_p[l][31:0]) * 64'(i_gain)) >> 32);
                end
                n_state = S_Q_OUT;
            end
            S_Q_OUT: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_RC_CLR: begin
                f_we = 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_state = S_RC_SRD;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_RC_SRD: begin
                m_re    = 1'b1;
                n_state = S_RC_SCHK;
            end
            S_RC_SCHK: begin
                if (m_rdata[32]) begin
                    n_m     = m_rdata[31:0];
                    n_i     = -rs;
                    n_j     = -rs;
                    n_state = S_RC_OFF;
                end else begin
                    adv_cell = 1'b1;
                end
            end
            S_RC_OFF: begin
                if (use_off) begin
                    f_re    = 1'b1;
                    f_raddr = tgt;
                    n_tgt   = tgt;
                    n_kx    = tab_kx[tix];
                    n_ky    = tab_ky[tix];
                    n_sgnx  = ~r_j[OFS_W-1] & (r_j != '0);
                    n_sgny  = ~r_i[OFS_W-1] & (r_i != '0);
                    n_state = S_RC_MUL;
                end else begin
                    n_state = S_RC_OFF;
                    adv_off = 1'b1;
                end
            end
            S_RC_MUL: begin
                n_fd    = f_rdata;
                n_px    = 45'((67'(r_m) * 67'(r_kx)) >> 22);
                n_py    = 45'((67'(r_m) * 67'(r_ky)) >> 22);
                n_state = S_RC_ADD;
            end
            S_RC_ADD: begin
                f_we    = 1'b1;
                f_waddr = r_tgt;
                f_wdata = {sat_add48($signed(r_fd[95:48]),
                                     r_sgnx ? -$signed({4'd0, r_px}) : $signed({4'd0, r_px})),
                           sat_add48($signed(r_fd[47:0]),
                                     r_sgny ? -$signed({4'd0, r_py}) : $signed({4'd0, r_py}))};
                n_state = S_RC_OFF;
                adv_off = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase

        // offset walk: column inner, row outer
        if (adv_off) begin
            if (r_j == rs) begin
                n_j = -rs;
                if (r_i == rs) begin
                    adv_cell = 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end else begin
                n_j = r_j + 1'b1;
            end
        end

        // source walk in ascending cell index
        if (adv_cell) begin
            if (r_addr == LAST) begin
                n_state = S_IDLE;
            end else begin
                n_state = S_RC_SRD;
                n_addr  = r_addr + 1'b1;
                if (r_sx == X_LAST) begin
                    n_sx = '0;
                    n_sy = r_sy + 1'b1;
                end else begin
                    n_sx = r_sx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;   r_sx   <= n_sx;   r_sy  <= n_sy;
        r_i     <= n_i;     r_j    <= n_j;    r_r   <= n_r;
        r_m     <= n_m;     r_kx   <= n_kx;   r_ky  <= n_ky;
        r_sgnx  <= n_sgnx;  r_sgny <= n_sgny; r_tgt <= n_tgt;
        r_px    <= n_px;    r_py   <= n_py;   r_fd  <= n_fd;
        r_qzero <= n_qzero;
        for (int l = 0; l < 2; l++) begin
            r_neg[l] <= n_neg[l];
            r_mag[l] <= n_mag[l];
            r_p[l]   <= n_p[l];
            r_a[l]   <= n_a[l];
            r_b[l]   <= n_b[l];
        end
    end
endmodule

// ===== sv/coarse_grid_gravity_field_top.sv =====
// coarse grid gravity field: top level with config registers and queues
// front: two quotient bits a cycle over the 10-bit positions; one word at a time, full while busy
// back: a move is a read-modify-write of the new, then the old cell's mass; a query scales the field by mass and gain
// recompute: clears the field, then reads the mass of each source cell, and for each active cell
//   makes (2r+1)^2 offset checks and a read-multiply-add of the field at each updated target
// after reset the memories are swept to zero; full stays high meanwhile
module coarse_grid_gravity_field_top import cggf_pkg::*; #(
    parameter int GRID_W     = 64,
    parameter int GRID_H     = 64,
    parameter int MAX_RADIUS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word side
    input  logic        push,
    output logic        full,
    input  t_in         i_item,
    // result word side
    output logic        empty,
    input  logic        pop,
    output t_out        o_result,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    // configuration registers
    logic [4:0]  r_cell_span;
    logic [31:0] r_threshold;
    logic [3:0]  r_radius;
    logic [31:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_span <= 5'd4;
            r_threshold <= 32'd256;
            r_radius    <= 4'd3;
            r_gain      <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELL_SPAN: r_cell_span <= i_cfg_data[4:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_RADIUS:    r_radius    <= i_cfg_data[3:0];
                CFG_GAIN:      r_gain      <= i_cfg_data;
                default:       r_gain      <= r_gain;
            endcase
        end
    end

    // front end busy or memory sweep after reset both hold off new words
    logic front_busy, clearing, take;
    assign full = front_busy | clearing;
    assign take = push & ~full;

    // front to back command queue
    logic cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd cmd_in, cmd_out;

    cggf_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_item     (i_item),
        .i_cell_span(r_cell_span),
        .i_q_full   (cmd_full),
        .o_busy     (front_busy),
        .o_push     (cmd_push),
        .o_cmd      (cmd_in)
    );

    cggf_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(2)) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_push),
        .i_data (cmd_in),
        .o_full (cmd_full),
        .o_empty(cmd_empty),
        .i_pop  (cmd_pop),
        .o_data (cmd_out)
    );

    // back end and result queue
    logic res_push, res_full;
    t_out res_word;
    logic [$bits(t_out)-1:0] res_bits;

    cggf_back #(.GRID_W(GRID_W), .GRID_H(GRID_H), .MAX_RADIUS(MAX_RADIUS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (cmd_empty),
        .o_q_pop    (cmd_pop),
        .i_cmd      (cmd_out),
        .i_threshold(r_threshold),
        .i_radius   (r_radius),
        .i_gain     (r_gain),
        .i_out_full (res_full),
        .o_out_push (res_push),
        .o_result   (res_word),
        .o_clearing (clearing)
    );

    cggf_fifo #(.WIDTH($bits(t_out)), .DEPTH(2)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_word),
        .o_full (res_full),
        .o_empty(empty),
        .i_pop  (pop),
        .o_data (res_bits)
    );

    assign o_result = t_out'(res_bits);
endmodule
